### sv/kpt_pkg.sv
// Shared constants, codes, command/status types and default map for the key target mapper.
package kpt_pkg;

  localparam int TARGET_COUNT_DEF     = 17;
  localparam int MATRIX_ROW_COUNT_DEF = 6;
  localparam int MATRIX_COL_COUNT_DEF = 21;

  localparam logic [7:0]  UNASSIGNED      = 8'hFF;
  localparam logic [4:0]  LAST_HID_TARGET = 5'd12;
  localparam logic [4:0]  ENCODER_TARGET  = 5'd12;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd30000;
  localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;

  // opcodes
  localparam logic [2:0] OP_KEY      = 3'd0;
  localparam logic [2:0] OP_ARM      = 3'd1;
  localparam logic [2:0] OP_SET      = 3'd2;
  localparam logic [2:0] OP_CLEAR    = 3'd3;
  localparam logic [2:0] OP_DEFAULTS = 3'd4;
  localparam logic [2:0] OP_READ     = 3'd5;
  localparam logic [2:0] OP_TICK     = 3'd6;

  // result kinds
  localparam logic [2:0] K_PASS     = 3'd0;
  localparam logic [2:0] K_SWALLOW  = 3'd1;
  localparam logic [2:0] K_HID      = 3'd2;
  localparam logic [2:0] K_JOY      = 3'd3;
  localparam logic [2:0] K_CAPTURED = 3'd4;
  localparam logic [2:0] K_ACK      = 3'd5;

  // ack status
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_TARGET = 2'd1;
  localparam logic [1:0] ST_BAD_POS    = 2'd2;

  // actions
  localparam logic [1:0] ACT_RELEASE = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;
  localparam logic [1:0] ACT_ROTATE  = 2'd2;

  typedef enum logic [2:0] {
    SM_MATCH    = 3'd0,
    SM_BIND     = 3'd1,
    SM_CLEAR    = 3'd2,
    SM_DEFAULTS = 3'd3,
    SM_READ     = 3'd4
  } scan_mode_t;

  typedef struct packed {
    logic in_ready;
    logic decide;
    logic scan;
    logic emit;
  } kpt_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic need_scan;
    logic scan_last;
    logic out_free;
  } kpt_sts_t;

  function automatic logic [7:0] default_row(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0, 5'd1, 5'd2, 5'd11: v = 8'd4;
      5'd3, 5'd4, 5'd5:        v = 8'd3;
      5'd6:                    v = 8'd2;
      5'd7, 5'd8, 5'd9, 5'd12: v = 8'd0;
      5'd10:                   v = 8'd5;
      default:                 v = UNASSIGNED;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] default_col(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0, 5'd3, 5'd7:         v = 8'd17;
      5'd1, 5'd4, 5'd9, 5'd10:  v = 8'd18;
      5'd2, 5'd5:               v = 8'd19;
      5'd6, 5'd8, 5'd11:        v = 8'd20;
      5'd12:                    v = 8'd13;
      default:                  v = UNASSIGNED;
    endcase
    return v;
  endfunction

endpackage

### sv/kpt_in_if.sv
// Input channel: key events and commands with valid/ready handshake.
interface kpt_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] row;
  logic [7:0] col;
  logic       pressed;
  logic [7:0] target;
  logic       is_encoder_turn;

  modport source (output valid, opcode, row, col, pressed, target, is_encoder_turn,
                  input ready);
  modport sink   (input valid, opcode, row, col, pressed, target, is_encoder_turn,
                  output ready);
endinterface

### sv/kpt_out_if.sv
// Result channel: mapped events and acks with valid/ready handshake.
interface kpt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [1:0] status;
  logic [4:0] event_target;
  logic [1:0] action;
  logic [7:0] event_row;
  logic [7:0] event_col;

  modport source (output valid, kind, status, event_target, action, event_row, event_col,
                  input ready);
  modport sink   (input valid, kind, status, event_target, action, event_row, event_col,
                  output ready);
endinterface

### sv/kpt_ctrl.sv
// Sequencer: accept, decide, table scan and result hand-off.
module kpt_ctrl
  import kpt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  kpt_sts_t sts,
  output kpt_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (sts.in_fire) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = sts.need_scan ? S_SCAN : S_FINISH;
      S_SCAN:   if (sts.scan_last) state_nxt = S_FINISH;
      S_FINISH: if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.in_ready = (state_r == S_IDLE);
  assign cmd.decide   = (state_r == S_DECIDE);
  assign cmd.scan     = (state_r == S_SCAN);
  assign cmd.emit     = (state_r == S_FINISH) && sts.out_free;

`ifndef SYNTHESIS
  a_fire_decides: assert property (@(posedge clk) disable iff (!rst_n)
    sts.in_fire |=> state_r == S_DECIDE)
    else $error("accepted beat did not reach decide");
  a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !sts.scan_last) |=> state_r == S_SCAN)
    else $error("scan left before last entry");
  a_emit_idles: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == S_IDLE && cmd.in_ready))
    else $error("not idle after result hand-off");
`endif

endmodule

### sv/kpt_dp.sv
// Datapath: item latch, position table, capture state, result and output registers.
module kpt_dp
  import kpt_pkg::*;
#(
  parameter int TargetCount = TARGET_COUNT_DEF,
  parameter int MatrixRows  = MATRIX_ROW_COUNT_DEF,
  parameter int MatrixCols  = MATRIX_COL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  kpt_cmd_t    cmd,
  output kpt_sts_t    sts,
  kpt_in_if.sink      in_ch,
  kpt_out_if.source   out_ch,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int TW = $clog2(TargetCount);
  localparam logic [TW-1:0] LastIdx = TW'(TargetCount - 1);

  // latched item
  logic [2:0] op_r;
  logic [7:0] row_r, col_r, tg_r;
  logic       pr_r, enc_r;

  // position table
  logic [7:0] tbl_row_r [TargetCount];
  logic [7:0] tbl_col_r [TargetCount];

  // capture and swallow state
  logic          armed_r, armed_nxt;
  logic [TW-1:0] cidx_r, cidx_nxt;
  logic [15:0]   elapsed_r, elapsed_nxt;
  logic          pend_r, pend_nxt;
  logic [7:0]    sr_r, sr_nxt, sc_r, sc_nxt;
  logic [15:0]   timeout_r;

  // scan
  scan_mode_t    mode_r, d_mode;
  logic [TW-1:0] idx_r, stgt_r, d_stgt;
  logic          found_r;

  // pending result
  logic [2:0] res_kind_r, d_kind;
  logic [1:0] res_status_r, d_status;
  logic [4:0] res_tgt_r, d_tgt;
  logic [1:0] res_action_r, d_action;
  logic [7:0] res_row_r, d_row, res_col_r, d_col;
  logic       d_need_scan;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_kind_r;
  logic [1:0] out_status_r;
  logic [4:0] out_tgt_r;
  logic [1:0] out_action_r;
  logic [7:0] out_row_r, out_col_r;

  logic          in_fire;
  logic          tgt_ok, pos_ok, expired, armed_eff, hit;
  logic [TW-1:0] t_idx;
  logic [15:0]   elapsed_inc;
  logic [1:0]    pr_act;

  assign in_ch.ready = cmd.in_ready;
  assign in_fire     = in_ch.valid && cmd.in_ready;

  assign tgt_ok    = tg_r < 8'(TargetCount);
  assign pos_ok    = (row_r < 8'(MatrixRows)) && (col_r < 8'(MatrixCols));
  assign t_idx     = tg_r[TW-1:0];
  assign expired   = armed_r && (elapsed_r >= timeout_r);
  assign armed_eff = armed_r && !expired;
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 16'd1;
  assign pr_act    = pr_r ? ACT_PRESS : ACT_RELEASE;
  assign hit       = (tbl_row_r[idx_r] == row_r) && (tbl_col_r[idx_r] == col_r);

  // per-opcode decision, applied in the decide cycle
  always_comb begin
    armed_nxt   = armed_r;
    cidx_nxt    = cidx_r;
    elapsed_nxt = elapsed_r;
    pend_nxt    = pend_r;
    sr_nxt      = sr_r;
    sc_nxt      = sc_r;
    d_kind      = K_ACK;
    d_status    = ST_OK;
    d_tgt       = 5'd0;
    d_action    = ACT_RELEASE;
    d_row       = 8'd0;
    d_col       = 8'd0;
    d_mode      = SM_MATCH;
    d_stgt      = t_idx;
    d_need_scan = 1'b0;
    unique case (op_r)
      OP_KEY: begin
        if (enc_r) begin
          d_kind   = K_HID;
          d_tgt    = ENCODER_TARGET;
          d_action = ACT_ROTATE;
          d_row    = {7'd0, pr_r};
          d_col    = col_r;
        end else if (!pos_ok) begin
          d_kind   = K_PASS;
          d_action = pr_act;
          d_row    = row_r;
          d_col    = col_r;
        end else if (!pr_r && pend_r && row_r == sr_r && col_r == sc_r) begin
          armed_nxt = armed_eff;
          pend_nxt  = 1'b0;
          d_kind    = K_SWALLOW;
          d_row     = row_r;
          d_col     = col_r;
        end else if (pr_r && armed_eff) begin
          armed_nxt   = 1'b0;
          pend_nxt    = 1'b1;
          sr_nxt      = row_r;
          sc_nxt      = col_r;
          d_kind      = K_CAPTURED;
          d_tgt       = 5'(cidx_r);
          d_action    = ACT_PRESS;
          d_row       = row_r;
          d_col       = col_r;
          d_mode      = SM_BIND;
          d_stgt      = cidx_r;
          d_need_scan = 1'b1;
        end else begin
          armed_nxt   = armed_eff;
          d_kind      = K_PASS;
          d_action    = pr_act;
          d_row       = row_r;
          d_col       = col_r;
          d_mode      = SM_MATCH;
          d_need_scan = 1'b1;
        end
      end
      OP_ARM: begin
        if (!tgt_ok) begin
          d_status = ST_BAD_TARGET;
        end else begin
          cidx_nxt    = t_idx;
          elapsed_nxt = 16'd0;
          armed_nxt   = 1'b1;
          d_tgt       = 5'(t_idx);
        end
      end
      OP_SET: begin
        if (!tgt_ok) begin
          d_status = ST_BAD_TARGET;
        end else if (!pos_ok) begin
          d_status = ST_BAD_POS;
          d_tgt    = 5'(t_idx);
        end else begin
          d_tgt       = 5'(t_idx);
          d_mode      = SM_BIND;
          d_need_scan = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (!tgt_ok) begin
          d_status = ST_BAD_TARGET;
        end else begin
          d_tgt       = 5'(t_idx);
          d_mode      = SM_CLEAR;
          d_need_scan = 1'b1;
        end
      end
      OP_DEFAULTS: begin
        d_mode      = SM_DEFAULTS;
        d_need_scan = 1'b1;
      end
      OP_READ: begin
        if (!tgt_ok) begin
          d_status = ST_BAD_TARGET;
        end else begin
          d_tgt       = 5'(t_idx);
          d_mode      = SM_READ;
          d_need_scan = 1'b1;
        end
      end
      OP_TICK: begin
        if (armed_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= timeout_r) armed_nxt = 1'b0;
        end
      end
      default: d_status = ST_BAD_TARGET;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      cidx_r      <= '0;
      elapsed_r   <= 16'd0;
      pend_r      <= 1'b0;
      sr_r        <= 8'd0;
      sc_r        <= 8'd0;
      timeout_r   <= TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.decide) begin
        armed_r   <= armed_nxt;
        cidx_r    <= cidx_nxt;
        elapsed_r <= elapsed_nxt;
        pend_r    <= pend_nxt;
        sr_r      <= sr_nxt;
        sc_r      <= sc_nxt;
      end
      if (cfg_wr_en) timeout_r <= cfg_wr_data;
      out_valid_r <= out_valid_nxt;
    end
  end

  // position table; reset loads the default map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TargetCount; i++) begin
        tbl_row_r[i] <= default_row(5'(i));
        tbl_col_r[i] <= default_col(5'(i));
      end
    end else if (cmd.scan) begin
      case (mode_r)
        SM_BIND: begin
          if (idx_r == stgt_r) begin
            tbl_row_r[idx_r] <= row_r;
            tbl_col_r[idx_r] <= col_r;
          end else if (hit) begin
            tbl_row_r[idx_r] <= UNASSIGNED;
            tbl_col_r[idx_r] <= UNASSIGNED;
          end
        end
        SM_CLEAR: begin
          if (idx_r == stgt_r) begin
            tbl_row_r[idx_r] <= UNASSIGNED;
            tbl_col_r[idx_r] <= UNASSIGNED;
          end
        end
        SM_DEFAULTS: begin
          tbl_row_r[idx_r] <= default_row(5'(idx_r));
          tbl_col_r[idx_r] <= default_col(5'(idx_r));
        end
        default: ;
      endcase
    end
  end

  // item latch, scan bookkeeping and result assembly
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_ch.opcode;
      row_r <= in_ch.row;
      col_r <= in_ch.col;
      pr_r  <= in_ch.pressed;
      tg_r  <= in_ch.target;
      enc_r <= in_ch.is_encoder_turn;
    end
    if (cmd.decide) begin
      mode_r       <= d_mode;
      stgt_r       <= d_stgt;
      idx_r        <= '0;
      found_r      <= 1'b0;
      res_kind_r   <= d_kind;
      res_status_r <= d_status;
      res_tgt_r    <= d_tgt;
      res_action_r <= d_action;
      res_row_r    <= d_row;
      res_col_r    <= d_col;
    end else if (cmd.scan) begin
      idx_r <= idx_r + TW'(1);
      // first matching entry wins
      if (mode_r == SM_MATCH && !found_r && hit) begin
        found_r    <= 1'b1;
        res_kind_r <= (5'(idx_r) <= LAST_HID_TARGET) ? K_HID : K_JOY;
        res_tgt_r  <= 5'(idx_r);
      end
      if (mode_r == SM_READ && idx_r == stgt_r) begin
        res_row_r <= tbl_row_r[idx_r];
        res_col_r <= tbl_col_r[idx_r];
      end
    end
    if (cmd.emit) begin
      out_kind_r   <= res_kind_r;
      out_status_r <= res_status_r;
      out_tgt_r    <= res_tgt_r;
      out_action_r <= res_action_r;
      out_row_r    <= res_row_r;
      out_col_r    <= res_col_r;
    end
  end

  always_comb begin
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.event_target = out_tgt_r;
  assign out_ch.action       = out_action_r;
  assign out_ch.event_row    = out_row_r;
  assign out_ch.event_col    = out_col_r;

  assign sts.in_fire   = in_fire;
  assign sts.need_scan = d_need_scan;
  assign sts.scan_last = (idx_r == LastIdx);
  assign sts.out_free  = !out_valid_r || out_ch.ready;

`ifndef SYNTHESIS
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("result beat lost at hand-off");
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> idx_r <= LastIdx)
    else $error("scan index past last table entry");
  a_tick_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.decide && op_r == OP_TICK && armed_r && elapsed_r == ELAPSED_MAX)
      |=> elapsed_r == ELAPSED_MAX)
    else $error("capture timer wrapped");
  a_capture_swallow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.decide && d_kind == K_CAPTURED) |=> (pend_r && !armed_r))
    else $error("capture did not arm release swallow");
`endif

endmodule

### sv/key_position_target_mapper.sv
// Top level of the key position to control target mapper.
// Table walks (good set, good clear, good read, defaults, non-encoder in-matrix key other than
// a swallowed release) pass through accept, decide, a scan of every table entry and finish;
// other items skip the scan. A new item is accepted only once the last one has finished.
// A waiting result beat holds only the finish step. Synchronous active-low reset loads
// the default map and a timeout of 30000 ticks, and clears capture and swallow state.
module key_position_target_mapper
  import kpt_pkg::*;
#(
  parameter int TargetCount = TARGET_COUNT_DEF,
  parameter int MatrixRows  = MATRIX_ROW_COUNT_DEF,
  parameter int MatrixCols  = MATRIX_COL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  kpt_in_if.sink      in_ch,
  kpt_out_if.source   out_ch,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  kpt_cmd_t cmd;
  kpt_sts_t sts;

  kpt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  kpt_dp #(
    .TargetCount (TargetCount),
    .MatrixRows  (MatrixRows),
    .MatrixCols  (MatrixCols)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule

### test/tb.sv
// Testbench for the key position target mapper: directed and random beats checked by a predictor.
module tb;
  import kpt_pkg::*;

  localparam int N_TARGETS = TARGET_COUNT_DEF;
  localparam int N_ROWS = MATRIX_ROW_COUNT_DEF;
  localparam int N_COLS = MATRIX_COL_COUNT_DEF;
  localparam int N_HOME = 13;
  localparam logic [2:0] OP_UNDEFINED = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int CHUNKS = 6;
  localparam int CHUNK_ITEMS = 67;

  // factory positions of targets 0..12; the rest start unassigned
  localparam logic [0:N_HOME-1][7:0] HOME_ROW = {
    8'd4, 8'd4, 8'd4, 8'd3, 8'd3, 8'd3, 8'd2, 8'd0, 8'd0, 8'd0, 8'd5, 8'd4, 8'd0
  };
  localparam logic [0:N_HOME-1][7:0] HOME_COL = {
    8'd17, 8'd18, 8'd19, 8'd17, 8'd18, 8'd19, 8'd20, 8'd17, 8'd20, 8'd18, 8'd18, 8'd20, 8'd13
  };
  localparam logic [0:CHUNKS-1][15:0] CHUNK_TIMEOUT = {
    16'd1, 16'd65535, 16'd0, 16'd2, 16'd3, TIMEOUT_RESET
  };

  typedef struct packed {
    logic       drain_first;
    logic [2:0] opcode;
    logic [7:0] row;
    logic [7:0] col;
    logic       pressed;
    logic [7:0] target;
    logic       enc;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] status;
    logic [4:0] event_target;
    logic [1:0] action;
    logic [7:0] event_row;
    logic [7:0] event_col;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  kpt_in_if  in_bus();
  kpt_out_if out_bus();

  key_position_target_mapper dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_bus),
    .out_ch(out_bus),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  cmd_t    pending_cmds[$];
  result_t predicted_results[$];

  // predictor state
  logic [7:0]  map_row[N_TARGETS];
  logic [7:0]  map_col[N_TARGETS];
  logic        armed;
  logic [4:0]  armed_target;
  logic [15:0] elapsed_ticks;
  logic        swallow_pending;
  logic [7:0]  swallow_row;
  logic [7:0]  swallow_col;
  logic [15:0] timeout_ticks;

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_next;
  bit  in_beat_taken;
  int  mismatches;
  int  beats_in;
  int  beats_out;
  int  quiet_cycles;
  int  kind_seen[8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void load_home_map();
    for (int i = 0; i < N_TARGETS; i++) begin
      map_row[i] = (i < N_HOME) ? HOME_ROW[i] : UNASSIGNED;
      map_col[i] = (i < N_HOME) ? HOME_COL[i] : UNASSIGNED;
    end
  endfunction

  // a position belongs to at most one target after a bind
  function automatic void claim_position(input logic [4:0] t, input logic [7:0] r,
                                         input logic [7:0] c);
    for (int i = 0; i < N_TARGETS; i++) begin
      if (i != t && map_row[i] == r && map_col[i] == c) begin
        map_row[i] = UNASSIGNED;
        map_col[i] = UNASSIGNED;
      end
    end
    map_row[t] = r;
    map_col[t] = c;
  endfunction

  function automatic result_t map_predict(input cmd_t c);
    result_t res;
    bit      on_matrix;
    bit      good_target;
    bit      found;
    res = '0;
    res.kind = K_ACK;
    on_matrix = (c.row < N_ROWS) && (c.col < N_COLS);
    good_target = c.target < N_TARGETS;
    case (c.opcode)
      OP_KEY: begin
        res.event_row = c.row;
        res.event_col = c.col;
        res.action = c.pressed ? ACT_PRESS : ACT_RELEASE;
        if (c.enc) begin
          res.kind = K_HID;
          res.event_target = ENCODER_TARGET;
          res.action = ACT_ROTATE;
          res.event_row = {7'd0, c.pressed};
        end else if (!on_matrix) begin
          res.kind = K_PASS;
        end else begin
          if (armed && elapsed_ticks >= timeout_ticks) armed = 1'b0;
          if (!c.pressed && swallow_pending && c.row == swallow_row &&
              c.col == swallow_col) begin
            swallow_pending = 1'b0;
            res.kind = K_SWALLOW;
          end else if (c.pressed && armed) begin
            armed = 1'b0;
            swallow_pending = 1'b1;
            swallow_row = c.row;
            swallow_col = c.col;
            claim_position(armed_target, c.row, c.col);
            res.kind = K_CAPTURED;
            res.event_target = armed_target;
          end else begin
            found = 1'b0;
            res.kind = K_PASS;
            for (int i = 0; i < N_TARGETS; i++) begin
              if (!found && map_row[i] == c.row && map_col[i] == c.col) begin
                found = 1'b1;
                res.kind = (i <= LAST_HID_TARGET) ? K_HID : K_JOY;
                res.event_target = 5'(i);
              end
            end
          end
        end
      end
      OP_ARM: begin
        if (!good_target) res.status = ST_BAD_TARGET;
        else begin
          armed_target = c.target[4:0];
          elapsed_ticks = '0;
          armed = 1'b1;
          res.event_target = c.target[4:0];
        end
      end
      OP_SET: begin
        if (!good_target) res.status = ST_BAD_TARGET;
        else if (!on_matrix) begin
          res.status = ST_BAD_POS;
          res.event_target = c.target[4:0];
        end else begin
          claim_position(c.target[4:0], c.row, c.col);
          res.event_target = c.target[4:0];
        end
      end
      OP_CLEAR: begin
        if (!good_target) res.status = ST_BAD_TARGET;
        else begin
          map_row[c.target[4:0]] = UNASSIGNED;
          map_col[c.target[4:0]] = UNASSIGNED;
          res.event_target = c.target[4:0];
        end
      end
      OP_DEFAULTS: load_home_map();
      OP_READ: begin
        if (!good_target) res.status = ST_BAD_TARGET;
        else begin
          res.event_target = c.target[4:0];
          res.event_row = map_row[c.target[4:0]];
          res.event_col = map_col[c.target[4:0]];
        end
      end
      OP_TICK: begin
        if (armed) begin
          if (elapsed_ticks != ELAPSED_MAX) elapsed_ticks = elapsed_ticks + 16'd1;
          if (elapsed_ticks >= timeout_ticks) armed = 1'b0;
        end
      end
      default: res.status = ST_BAD_TARGET;
    endcase
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic add_cmd(input logic [2:0] op, input logic [7:0] r, input logic [7:0] c,
                         input logic p, input logic [7:0] t, input logic e);
    cmd_t cmd;
    cmd.drain_first = hold_next || ($urandom_range(99) < 3);
    cmd.opcode = op;
    cmd.row = r;
    cmd.col = c;
    cmd.pressed = p;
    cmd.target = t;
    cmd.enc = e;
    hold_next = 1'b0;
    pending_cmds.push_back(cmd);
  endtask

  // one short random sequence; mostly well-formed key and capture traffic
  task automatic add_random_burst();
    int unsigned pick;
    int unsigned h;
    logic [7:0]  r;
    logic [7:0]  c;
    logic [7:0]  t;
    pick = $urandom_range(99);
    h = $urandom_range(N_HOME - 1);
    if ($urandom_range(1)) begin
      r = HOME_ROW[h];
      c = HOME_COL[h];
    end else begin
      r = 8'($urandom_range(N_ROWS - 1));
      c = 8'($urandom_range(N_COLS - 1));
    end
    t = 8'($urandom_range(N_TARGETS - 1));
    if (pick < 28) begin
      add_cmd(OP_KEY, r, c, 1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0);
    end else if (pick < 34) begin
      add_cmd(OP_KEY, 8'($urandom_range(255)), 8'($urandom_range(255)),
              1'($urandom_range(1)), 8'($urandom_range(255)), 1'b1);
    end else if (pick < 39) begin
      add_cmd(OP_KEY, 8'($urandom_range(255)), 8'($urandom_range(255)),
              1'($urandom_range(1)), 0, 1'b0);
    end else if (pick < 52) begin
      add_cmd(OP_ARM, 0, 0, 0, t, 1'b0);
      repeat ($urandom_range(3)) add_cmd(OP_TICK, 0, 0, 0, 0, 1'b0);
      add_cmd(OP_KEY, r, c, 1'b1, 0, 1'b0);
      if ($urandom_range(1))
        add_cmd(OP_KEY, 8'($urandom_range(N_ROWS - 1)), 8'($urandom_range(N_COLS - 1)),
                1'($urandom_range(1)), 0, 1'b0);
      add_cmd(OP_KEY, r, c, 1'b0, 0, 1'b0);
    end else if (pick < 60) begin
      add_cmd(OP_SET, 8'($urandom_range(N_ROWS + 1)), 8'($urandom_range(N_COLS + 2)), 0,
              8'($urandom_range(N_TARGETS + 1)), 1'b0);
    end else if (pick < 65) begin
      add_cmd(OP_CLEAR, 0, 0, 0, 8'($urandom_range(N_TARGETS + 1)), 1'b0);
    end else if (pick < 75) begin
      add_cmd(OP_READ, 0, 0, 0, 8'($urandom_range(N_TARGETS + 1)), 1'b0);
    end else if (pick < 77) begin
      add_cmd(OP_DEFAULTS, 0, 0, 0, 0, 1'b0);
    end else if (pick < 90) begin
      add_cmd(OP_TICK, 0, 0, 0, 0, 1'b0);
    end else begin
      add_cmd(3'($urandom_range(7)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    timeout_ticks = value;
  endtask

  // input driver: holds a presented beat until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_beat_taken) begin
      if (pending_cmds.size() != 0 &&
          !(pending_cmds[0].drain_first && predicted_results.size() != 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        in_bus.valid <= 1'b1;
        in_bus.opcode <= pending_cmds[0].opcode;
        in_bus.row <= pending_cmds[0].row;
        in_bus.col <= pending_cmds[0].col;
        in_bus.pressed <= pending_cmds[0].pressed;
        in_bus.target <= pending_cmds[0].target;
        in_bus.is_encoder_turn <= pending_cmds[0].enc;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
    in_beat_taken = 1'b0;
    out_bus.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // accepted input beats feed the predictor; result beats are checked in order
  always @(posedge clk) begin
    result_t got;
    result_t want;
    bit      moved;
    moved = 1'b0;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      predicted_results.push_back(map_predict(pending_cmds.pop_front()));
      in_beat_taken = 1'b1;
      beats_in++;
      moved = 1'b1;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      moved = 1'b1;
      beats_out++;
      kind_seen[out_bus.kind]++;
      if (predicted_results.size() == 0) begin
        $error("unexpected result beat: kind %0d target %0d", out_bus.kind,
               out_bus.event_target);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        got.kind = out_bus.kind;
        got.status = out_bus.status;
        got.event_target = out_bus.event_target;
        got.action = out_bus.action;
        got.event_row = out_bus.event_row;
        got.event_col = out_bus.event_col;
        check_field("kind", 32'(want.kind), 32'(got.kind));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("event_target", 32'(want.event_target), 32'(got.event_target));
        check_field("action", 32'(want.action), 32'(got.action));
        check_field("event_row", 32'(want.event_row), 32'(got.event_row));
        check_field("event_col", 32'(want.event_col), 32'(got.event_col));
      end
    end
    if (!rst_n || moved) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_bus.valid = 1'b0;
    in_bus.opcode = OP_KEY;
    in_bus.row = '0;
    in_bus.col = '0;
    in_bus.pressed = 1'b0;
    in_bus.target = '0;
    in_bus.is_encoder_turn = 1'b0;
    out_bus.ready = 1'b0;
    in_beat_taken = 1'b0;
    hold_next = 1'b0;
    mismatches = 0;
    beats_in = 0;
    beats_out = 0;
    quiet_cycles = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    load_home_map();
    armed = 1'b0;
    armed_target = '0;
    elapsed_ticks = '0;
    swallow_pending = 1'b0;
    swallow_row = '0;
    swallow_col = '0;
    timeout_ticks = TIMEOUT_RESET;
    send_idle_pct = 28;
    recv_idle_pct = 83;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, default timeout
    add_cmd(OP_READ, 0, 0, 0, 0, 1'b0);
    add_cmd(OP_READ, 0, 0, 0, 16, 1'b0);
    add_cmd(OP_READ, 0, 0, 0, 255, 1'b0);
    add_cmd(OP_KEY, 4, 17, 1'b1, 0, 1'b0);
    add_cmd(OP_KEY, 4, 17, 1'b0, 0, 1'b0);
    add_cmd(OP_KEY, 0, 13, 1'b1, 0, 1'b0);
    add_cmd(OP_KEY, 255, 255, 1'b1, 255, 1'b1);
    add_cmd(OP_KEY, 0, 0, 1'b0, 0, 1'b1);
    add_cmd(OP_KEY, 8'(N_ROWS), 0, 1'b1, 0, 1'b0);
    add_cmd(OP_KEY, 0, 8'(N_COLS), 1'b0, 0, 1'b0);
    add_cmd(OP_SET, 5, 0, 0, 16, 1'b0);
    add_cmd(OP_KEY, 5, 0, 1'b1, 0, 1'b0);
    add_cmd(OP_SET, 0, 0, 0, 17, 1'b0);
    add_cmd(OP_SET, 8'(N_ROWS), 5, 0, 3, 1'b0);
    // capture steals target 0's key; the release after it is eaten once
    add_cmd(OP_ARM, 0, 0, 0, 3, 1'b0);
    add_cmd(OP_TICK, 0, 0, 0, 0, 1'b0);
    add_cmd(OP_KEY, 4, 17, 1'b1, 0, 1'b0);
    add_cmd(OP_KEY, 5, 0, 1'b0, 0, 1'b0);
    add_cmd(OP_KEY, 4, 17, 1'b0, 0, 1'b0);
    add_cmd(OP_KEY, 4, 17, 1'b0, 0, 1'b0);
    add_cmd(OP_READ, 0, 0, 0, 0, 1'b0);
    add_cmd(OP_CLEAR, 0, 0, 0, 200, 1'b0);
    add_cmd(OP_CLEAR, 0, 0, 0, 16, 1'b0);
    add_cmd(OP_ARM, 0, 0, 0, 255, 1'b0);
    add_cmd(OP_ARM, 0, 0, 0, 1, 1'b0);
    add_cmd(OP_ARM, 0, 0, 0, 2, 1'b0);
    add_cmd(OP_KEY, 1, 1, 1'b1, 0, 1'b0);
    add_cmd(OP_DEFAULTS, 0, 0, 0, 0, 1'b0);
    add_cmd(OP_UNDEFINED, 0, 0, 0, 0, 1'b0);
    add_cmd(OP_KEY, 1, 2, 1'b1, 0, 1'b0);
    wait_idle();

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      send_idle_pct = (chunk < 2) ? 28 : (chunk < 4) ? 83 : 0;
      recv_idle_pct = (chunk < 2) ? 83 : (chunk < 4) ? 28 : 0;
      write_timeout(CHUNK_TIMEOUT[chunk]);
      hold_next = 1'b1;
      while (pending_cmds.size() < CHUNK_ITEMS) add_random_burst();
      wait_idle();
    end

    $display("Ran %0d command beats and %0d result beats over %0d timeout settings",
             beats_in, beats_out, CHUNKS + 1);
    $display("Kinds seen: pass %0d swallow %0d hid %0d joystick %0d captured %0d ack %0d",
             kind_seen[K_PASS], kind_seen[K_SWALLOW], kind_seen[K_HID], kind_seen[K_JOY],
             kind_seen[K_CAPTURED], kind_seen[K_ACK]);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
